/* sv/dsfy_pkg.sv */
// Shared constants, types and a helper function for the deck shuffler.
package dsfy_pkg;

    localparam int DeckSize   = 52;
    localparam int PosW       = 6;
    localparam int CardW      = 9;
    localparam int RandW      = 31;
    localparam int RandomBits = 31;
    localparam int RemW       = 6;

    localparam logic [PosW-1:0] TopPos = PosW'(DeckSize - 1);

    localparam logic [RandW-1:0] RandMask =
        (RandomBits >= RandW) ? {RandW{1'b1}} : RandW'((64'd1 << RandomBits) - 64'd1);

    localparam logic [CardW-1:0] Suit1Base = 9'd102;
    localparam logic [CardW-1:0] Suit2Base = 9'd202;
    localparam logic [CardW-1:0] Suit3Base = 9'd302;
    localparam logic [CardW-1:0] Suit4Base = 9'd402;
    localparam logic [PosW-1:0]  SuitLen   = 6'd13;

    // Deck memory request: one read port, one write port, flash clear.
    typedef struct packed {
        logic [PosW-1:0]  rd_addr;
        logic             wr_en;
        logic [PosW-1:0]  wr_addr;
        logic [CardW-1:0] wr_data;
        logic             clear;
    } t_mem_req;

    // Card at a position of the ordered deck.
    function automatic logic [CardW-1:0] ordered_card(input logic [PosW-1:0] pos);
        logic [CardW-1:0] base;
        logic [PosW-1:0]  rank;
        if (pos < SuitLen) begin
            base = Suit1Base;
            rank = pos;
        end else if (pos < PosW'(2 * 13)) begin
            base = Suit2Base;
            rank = pos - SuitLen;
        end else if (pos < PosW'(3 * 13)) begin
            base = Suit3Base;
            rank = pos - PosW'(2 * 13);
        end else begin
            base = Suit4Base;
            rank = pos - PosW'(3 * 13);
        end
        return base + CardW'(rank);
    endfunction

endpackage

/* sv/dsfy_mod.sv */
// Bit-serial restoring modulo unit: remainder of a random word by a small divisor.
module dsfy_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dsfy_pkg::RandW-1:0]  i_dividend,
    input  logic [dsfy_pkg::PosW:0]     i_divisor,
    output logic                        o_done,
    output logic [dsfy_pkg::RemW-1:0]   o_rem
);

    localparam int CntW = $clog2(dsfy_pkg::RandW);

    logic                        r_busy;
    logic [CntW-1:0]             r_cnt;
    logic [dsfy_pkg::RandW-1:0]  r_num;
    logic [dsfy_pkg::PosW:0]     r_div;
    logic [dsfy_pkg::RemW-1:0]   r_rem;
    logic [dsfy_pkg::RemW:0]     trial;
    logic [dsfy_pkg::RemW-1:0]   n_rem;

    // Shift in one dividend bit, subtract the divisor when it fits.
    always_comb begin
        trial = {r_rem, r_num[dsfy_pkg::RandW-1]};
        if (trial >= (dsfy_pkg::RemW+1)'(r_div)) begin
            n_rem = dsfy_pkg::RemW'(trial - (dsfy_pkg::RemW+1)'(r_div));
        end else begin
            n_rem = trial[dsfy_pkg::RemW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= CntW'(dsfy_pkg::RandW - 1);
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= {r_num[dsfy_pkg::RandW-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_rem = r_rem;

endmodule

/* sv/dsfy_deck_mem.sv */
// Deck store: synchronous memory with per-entry valid bits that fall back to the ordered deck.
module dsfy_deck_mem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dsfy_pkg::t_mem_req          i_req,
    output logic [dsfy_pkg::CardW-1:0]  o_rd_card
);

    logic [dsfy_pkg::CardW-1:0] r_mem [dsfy_pkg::DeckSize];
    logic [dsfy_pkg::DeckSize-1:0] r_valid;
    logic [dsfy_pkg::CardW-1:0] r_rd_data;
    logic                       r_rd_valid;
    logic [dsfy_pkg::PosW-1:0]  r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
        r_rd_addr <= i_req.rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[i_req.rd_addr];
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    // Unwritten entries read as the ordered deck.
    assign o_rd_card = r_rd_valid ? r_rd_data : dsfy_pkg::ordered_card(r_rd_addr);

endmodule

/* sv/deck_shuffle_fisher_yates_top.sv */
// Top level of the Fisher-Yates deck shuffler: control sequencer, modulo unit and deck store.
// Swap step (shuffle on, position above 0): busy while the bit-serial modulo unit runs, then
//   for four deck memory accesses (read i, read j, write i, write j).
// Deck emission (final step or shuffle off): busy for one memory read per card, then a flush;
//   strobes come on consecutive cycles, one per card, each following its read through the pipeline.
// The receiver cannot stall; each result lives on the ports for one cycle only.
// Reset (synchronous, active low): ordered deck, step index 51, shuffling enabled.
module deck_shuffle_fisher_yates_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [dsfy_pkg::RandW-1:0]  i_random_value,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_wdata,
    output logic                        o_strobe,
    output logic [dsfy_pkg::CardW-1:0]  o_card_code,
    output logic [dsfy_pkg::PosW-1:0]   o_deck_position,
    output logic                        o_last_card
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_RDI,
        S_RDJ,
        S_WRI,
        S_WRJ,
        S_EMIT,
        S_FLUSH
    } t_state;

    t_state                      r_state;
    logic                        r_shuf_en;
    logic [dsfy_pkg::PosW-1:0]   r_step;
    logic [dsfy_pkg::PosW-1:0]   r_i;
    logic [dsfy_pkg::PosW-1:0]   r_j;
    logic [dsfy_pkg::CardW-1:0]  r_di;
    logic [dsfy_pkg::PosW-1:0]   r_pos;
    logic                        r_ord;
    logic                        r_e_v;
    logic [dsfy_pkg::PosW-1:0]   r_e_pos;

    logic                        accept;
    logic [dsfy_pkg::PosW-1:0]   cur_i;
    logic                        mod_start;
    logic                        mod_done;
    logic [dsfy_pkg::RemW-1:0]   mod_rem;
    dsfy_pkg::t_mem_req          mem_req;
    logic [dsfy_pkg::CardW-1:0]  rd_card;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Clamp an out-of-range step index to the top position.
    assign cur_i = (r_step > dsfy_pkg::TopPos) ? dsfy_pkg::TopPos : r_step;

    // Kick the modulo unit on a transfer that needs a real swap.
    assign mod_start = accept && r_shuf_en && (cur_i != '0);

    dsfy_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (i_random_value & dsfy_pkg::RandMask),
        .i_divisor  ((dsfy_pkg::PosW+1)'(cur_i) + 1'b1),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // Memory access pattern per state.
    always_comb begin
        mem_req         = '0;
        mem_req.rd_addr = r_pos;
        unique case (r_state)
            S_RDI: mem_req.rd_addr = r_i;
            S_RDJ: mem_req.rd_addr = r_j;
            S_WRI: begin
                // Read data now holds entry j: move it to position i.
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_i;
                mem_req.wr_data = rd_card;
            end
            S_WRJ: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_j;
                mem_req.wr_data = r_di;
            end
            S_FLUSH: mem_req.clear = !r_ord;
            S_IDLE, S_MOD, S_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    dsfy_deck_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_card (rd_card)
    );

    // Sequencer and registered result outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_shuf_en <= 1'b1;
            r_step    <= dsfy_pkg::TopPos;
            r_ord     <= 1'b0;
            r_e_v     <= 1'b0;
            o_strobe  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_shuf_en <= i_cfg_wdata;
            end

            // Emission pipeline: address issue, memory read, output register.
            r_e_v           <= (r_state == S_EMIT);
            r_e_pos         <= r_pos;
            o_strobe        <= r_e_v;
            o_deck_position <= r_e_pos;
            o_last_card     <= r_e_v && (r_e_pos == '0);
            o_card_code     <= r_ord ? dsfy_pkg::ordered_card(r_e_pos) : rd_card;

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_pos <= dsfy_pkg::TopPos;
                        r_i   <= cur_i;
                        if (!r_shuf_en) begin
                            r_ord   <= 1'b1;
                            r_state <= S_EMIT;
                        end else if (cur_i == '0) begin
                            // Final step swaps entry 0 with itself: go straight to output.
                            r_ord   <= 1'b0;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        r_j     <= dsfy_pkg::PosW'(mod_rem);
                        r_state <= S_RDI;
                    end
                end
                S_RDI: r_state <= S_RDJ;
                S_RDJ: begin
                    r_di    <= rd_card;
                    r_state <= S_WRI;
                end
                S_WRI: r_state <= S_WRJ;
                S_WRJ: begin
                    r_step  <= r_i - 1'b1;
                    r_state <= S_IDLE;
                end
                S_EMIT: begin
                    r_pos <= r_pos - 1'b1;
                    if (r_pos == '0) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    // Shuffled deck done: reload the ordered deck and restart the count.
                    if (!r_ord) begin
                        r_step <= dsfy_pkg::TopPos;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Last card marks position 0 only.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last_card |-> o_deck_position == '0)
        else $error("last card flag away from position 0");

    // Cards of one deck come out on consecutive cycles, counting down.
    a_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_deck_position != '0) |=>
            o_strobe && (o_deck_position == $past(o_deck_position) - 1'b1))
        else $error("emission sequence broken");

    // Step index never leaves the deck.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= dsfy_pkg::TopPos)
        else $error("step index out of range");

    // The modulo unit finishes only while the sequencer waits for it.
    a_mod_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> r_state == S_MOD)
        else $error("modulo result outside wait state");

endmodule

/* test/tb_deck_shuffle_fisher_yates_top.sv */
// Self-checking testbench for the deck shuffler: per-step shuffle prediction against emitted decks.
module tb_deck_shuffle_fisher_yates_top;

    // Keep the run bounded. The slowest legal run is roughly 360 draws, each a whole
    // deck emission plus the longest sender gap, plus the drains before each register write.
    localparam int CycleLimit = 400_000;
    localparam int DrawTarget = 300;
    localparam int SettleCycles = 60;

    // Predicted deck state plus the queue of cards still owed by the block.
    class deck_scoreboard;
        typedef struct packed {
            logic [dsfy_pkg::CardW-1:0] code;
            logic [dsfy_pkg::PosW-1:0]  pos;
            logic                       last;
        } t_card;

        logic [dsfy_pkg::CardW-1:0] deck [dsfy_pkg::DeckSize];
        logic [dsfy_pkg::PosW-1:0]  step;
        bit                         enable;
        t_card                      owed_cards[$];
        int                         failures;

        function new();
            load_ordered();
            step     = dsfy_pkg::TopPos;
            enable   = 1'b1;
            failures = 0;
        endfunction

        function logic [dsfy_pkg::CardW-1:0] fresh_card(int unsigned pos);
            return dsfy_pkg::CardW'((pos / 13 + 1) * 100 + 2 + pos % 13);
        endfunction

        function void load_ordered();
            for (int p = 0; p < dsfy_pkg::DeckSize; p++) deck[p] = fresh_card(p);
        endfunction

        function void owe_deck(bit ordered);
            t_card c;
            for (int p = dsfy_pkg::DeckSize - 1; p >= 0; p--) begin
                c.code = ordered ? fresh_card(p) : deck[p];
                c.pos  = dsfy_pkg::PosW'(p);
                c.last = (p == 0);
                owed_cards.push_back(c);
            end
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10) $display("mismatch: %s", msg);
        endfunction

        function void set_enable(logic value);
            enable = value;
        endfunction

        // One accepted draw: a swap step, or a whole deck when shuffling is off.
        function void note_draw(logic [dsfy_pkg::RandW-1:0] value);
            logic [dsfy_pkg::RandW-1:0] r;
            int unsigned                i;
            int unsigned                j;
            logic [dsfy_pkg::CardW-1:0] held;
            if (!enable) begin
                owe_deck(1'b1);
                return;
            end
            r    = value & dsfy_pkg::RandMask;
            i    = (step > dsfy_pkg::TopPos) ? dsfy_pkg::TopPos : step;
            j    = {1'b0, r} % (i + 1);
            held    = deck[i];
            deck[i] = deck[j];
            deck[j] = held;
            if (i == 0) begin
                owe_deck(1'b0);
                load_ordered();
                step = dsfy_pkg::TopPos;
            end else begin
                step = dsfy_pkg::PosW'(i - 1);
            end
        endfunction

        function void check_card(logic [dsfy_pkg::CardW-1:0] code,
                                 logic [dsfy_pkg::PosW-1:0] pos, logic last);
            t_card want;
            if (owed_cards.size() == 0) begin
                flag($sformatf("unexpected card code=%0d pos=%0d last=%0b", code, pos, last));
                return;
            end
            want = owed_cards.pop_front();
            if (code !== want.code || pos !== want.pos || last !== want.last)
                flag($sformatf("card exp code=%0d pos=%0d last=%0b got code=%0d pos=%0d last=%0b",
                               want.code, want.pos, want.last, code, pos, last));
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [dsfy_pkg::RandW-1:0] i_random_value;
    logic                       i_cfg_we;
    logic                       i_cfg_wdata;
    logic                       o_strobe;
    logic [dsfy_pkg::CardW-1:0] o_card_code;
    logic [dsfy_pkg::PosW-1:0]  o_deck_position;
    logic                       o_last_card;

    deck_scoreboard sb = new();
    int             cycle_count = 0;
    int             draws_sent = 0;
    bit             quiet = 1'b0;

    deck_shuffle_fisher_yates_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_random_value (i_random_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_card_code    (o_card_code),
        .o_deck_position(o_deck_position),
        .o_last_card    (o_last_card)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sample everything at the rising edge. Check cards before noting a new
    // draw: a card on the ports always belongs to an earlier transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) sb.check_card(o_card_code, o_deck_position, o_last_card);
            if (i_cfg_we) sb.set_enable(i_cfg_wdata);
            if (start && !busy) sb.note_draw(i_random_value);
        end
    end

    // Abort on a hang.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    // Present one draw and hold it until the transfer; leave start high so
    // a back-to-back draw follows without a gap.
    task automatic send_draw(input logic [dsfy_pkg::RandW-1:0] value);
        i_random_value = value;
        start          = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        draws_sent++;
        @(negedge i_clk);
    endtask

    // Idle the sender in about 31 of 100 slots; mostly short gaps, now and
    // then a long one so the next start lands deep inside a busy window.
    task automatic sender_pause();
        int gap;
        if (quiet || $urandom_range(99) >= 31) return;
        gap   = ($urandom_range(7) == 0) ? $urandom_range(4, 60) : $urandom_range(1, 3);
        start = 1'b0;
        repeat (gap) @(negedge i_clk);
    endtask

    // Write the shuffle enable only with the block idle: drain owed cards,
    // let a pending swap step finish, then pulse the write enable.
    task automatic write_shuffle_enable(input logic value);
        start = 1'b0;
        while (sb.owed_cards.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
        while (busy) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Pick a random word, steering some toward self swaps, swaps with
    // position 0, and the extremes of the field.
    function automatic logic [dsfy_pkg::RandW-1:0] draw_value();
        int unsigned span;
        span = sb.step + 1;
        case ($urandom_range(9))
            0: return dsfy_pkg::RandW'(sb.step + span * $urandom_range(0, 1000));
            1: return dsfy_pkg::RandW'(span * $urandom_range(0, 1000));
            2: return {dsfy_pkg::RandW{1'b1}};
            3: return dsfy_pkg::RandW'($urandom_range(0, 63));
            default: return dsfy_pkg::RandW'($urandom);
        endcase
    endfunction

    initial begin
        int phase_len;
        bit want_enable;

        // Drive every input known from time zero with reset held, then release it.
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_random_value = '0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: extremes of the random word on the first steps, a self
        // swap at position 49, alternating bit patterns.
        send_draw('0);
        send_draw({dsfy_pkg::RandW{1'b1}});
        send_draw(dsfy_pkg::RandW'(49));
        send_draw(dsfy_pkg::RandW'(31'h5555_5555));
        send_draw(dsfy_pkg::RandW'(31'h2AAA_AAAA));

        // Shuffling off mid-deck: expect the ordered deck each transfer and
        // the partial shuffle kept for later.
        write_shuffle_enable(1'b0);
        send_draw('0);
        send_draw({dsfy_pkg::RandW{1'b1}});
        write_shuffle_enable(1'b1);
        send_draw(dsfy_pkg::RandW'(12345));
        send_draw(dsfy_pkg::RandW'(1));

        // Random phases: long shuffle runs, occasional short runs with
        // shuffling off, and one stretch with no sender idling.
        while (draws_sent < DrawTarget) begin
            want_enable = ($urandom_range(7) != 0);
            if (want_enable != sb.enable) write_shuffle_enable(want_enable);
            phase_len = want_enable ? $urandom_range(20, 80) : $urandom_range(1, 3);
            repeat (phase_len) begin
                quiet = (draws_sent >= 100 && draws_sent < 160);
                sender_pause();
                send_draw(draw_value());
            end
        end

        // Finish a deck in flight so its cards are checked too.
        if (!sb.enable) write_shuffle_enable(1'b1);
        while (sb.step != dsfy_pkg::TopPos) send_draw(draw_value());
        start = 1'b0;

        // Drain and settle, then give the verdict.
        while (sb.owed_cards.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        if (sb.owed_cards.size() != 0) sb.flag("cards still owed at end of run");
        if (sb.failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
